// ===== hdl/fud_pkg.sv =====
package fud_pkg;

  // Characters the decoder looks for
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;

  // Results one byte can give at most
  localparam int unsigned MaxRes = 3;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       body_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       in_value;
    logic       pair_end;
    logic       pair_ok;
    logic       run_last;
  } out_word_t;

  // Segment state carried from byte to byte
  typedef struct packed {
    esc_phase_e phase;
    logic [3:0] high_nibble;
    logic       seen_equals;
    logic       body_stopped;
  } dec_state_t;

  // Fill status of the result buffer
  typedef struct packed {
    logic [1:0] cnt;
    logic [1:0] idx;
  } buf_status_t;

  // Unchecked hex digit value; may reach 24
  function automatic logic [4:0] nibble(input logic [7:0] c);
    nibble = {1'b0, c[3:0]} + (c[6] ? 5'd9 : 5'd0);
  endfunction

  function automatic out_word_t char_word(input logic [7:0] c, input logic val);
    out_word_t w;
    w = '0;
    w.out_char   = c;
    w.char_valid = 1'b1;
    w.in_value   = val;
    char_word    = w;
  endfunction

  function automatic out_word_t pair_word(input logic ok);
    out_word_t w;
    w = '0;
    w.pair_end = 1'b1;
    w.pair_ok  = ok;
    pair_word  = w;
  endfunction

endpackage

// ===== hdl/fud_decode.sv =====
module fud_decode
  import fud_pkg::*;
(
  input  in_word_t   in_i,
  input  dec_state_t st_i,
  input  logic       conv_i,
  output dec_state_t st_o,
  output out_word_t  res_o [MaxRes],
  output logic [1:0] cnt_o
);

  dec_state_t nxt;
  out_word_t  res [MaxRes];
  logic [1:0] cnt;
  logic [7:0] c;
  logic [7:0] dec;
  logic       have;
  logic [4:0] nib;

  // Decode one raw byte into up to three result words
  always_comb begin
    nxt  = st_i;
    cnt  = 2'd0;
    for (int i = 0; i < MaxRes; i++) res[i] = '0;
    c    = '0;
    dec  = '0;
    have = 1'b0;
    nib  = '0;

    if (st_i.body_stopped) begin
      if (in_i.body_end) nxt.body_stopped = 1'b0;
    end else if (in_i.in_byte == CH_NUL) begin
      res[cnt] = pair_word(nxt.seen_equals);
      cnt = cnt + 2'd1;
      nxt.phase = ESC_NONE;
      nxt.high_nibble = '0;
      nxt.seen_equals = 1'b0;
      if (!in_i.body_end) nxt.body_stopped = 1'b1;
    end else begin
      if (in_i.in_byte == CH_AMP) begin
        res[cnt] = pair_word(nxt.seen_equals);
        cnt = cnt + 2'd1;
        nxt.phase = ESC_NONE;
        nxt.high_nibble = '0;
        nxt.seen_equals = 1'b0;
      end else begin
        c   = (in_i.in_byte == CH_PLUS) ? CH_SPACE : in_i.in_byte;
        nib = nibble(c);
        // escape sequencing
        unique case (nxt.phase)
          ESC_HIGH: begin
            nxt.high_nibble = nib[3:0];
            nxt.phase = ESC_LOW;
          end
          ESC_LOW: begin
            dec  = {nxt.high_nibble, 4'h0} | {3'b000, nib};
            have = 1'b1;
            nxt.phase = ESC_NONE;
            nxt.high_nibble = '0;
          end
          default: begin
            if (c == CH_PCT) begin
              nxt.phase = ESC_HIGH;
            end else begin
              dec  = c;
              have = 1'b1;
            end
          end
        endcase
        // name/value split and newline conversion
        if (have) begin
          if (!nxt.seen_equals) begin
            if (dec == CH_EQ) begin
              nxt.seen_equals = 1'b1;
            end else begin
              res[cnt] = char_word(dec, 1'b0);
              cnt = cnt + 2'd1;
            end
          end else if (conv_i && dec == CH_CR) begin
            // CR dropped
          end else if (conv_i && dec == CH_LF) begin
            res[cnt] = char_word(CH_BSL, 1'b1);
            cnt = cnt + 2'd1;
            res[cnt] = char_word(CH_N, 1'b1);
            cnt = cnt + 2'd1;
          end else begin
            if (conv_i && dec == CH_PCT) begin
              res[cnt] = char_word(CH_PCT, 1'b1);
              cnt = cnt + 2'd1;
            end
            res[cnt] = char_word(dec, 1'b1);
            cnt = cnt + 2'd1;
          end
        end
      end
      if (in_i.body_end) begin
        res[cnt] = pair_word(nxt.seen_equals);
        cnt = cnt + 2'd1;
        nxt.phase = ESC_NONE;
        nxt.high_nibble = '0;
        nxt.seen_equals = 1'b0;
      end
    end

    // flag the last word of the run
    for (int i = 0; i < MaxRes; i++) res[i].run_last = (2'(i + 1) == cnt);
  end

  assign st_o  = nxt;
  assign res_o = res;
  assign cnt_o = cnt;

endmodule

// ===== hdl/fud_out_buf.sv =====
module fud_out_buf
  import fud_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  out_word_t   res_i [MaxRes],
  input  logic [1:0]  cnt_i,
  output logic        space_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o,
  output buf_status_t status_o
);

  out_word_t  res_q [MaxRes];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       take;

  assign out_valid_o = (idx_q != cnt_q);
  assign take        = out_valid_o && out_ready_i;
  // room for a new run once the last word leaves
  assign space_o     = !out_valid_o || (take && (idx_q + 2'd1 == cnt_q));

  // pointer update
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (take) idx_d = idx_q + 2'd1;
    if (load_i) begin
      cnt_d = cnt_i;
      idx_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // result words, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  // word select
  always_comb begin
    unique case (idx_q)
      2'd0:    out_data_o = res_q[0];
      2'd1:    out_data_o = res_q[1];
      2'd2:    out_data_o = res_q[2];
      default: out_data_o = '0;
    endcase
  end

  assign status_o = '{cnt: cnt_q, idx: idx_q};

endmodule

// ===== hdl/form_urlencoded_decoder_core.sv =====
// The result words of an accepted byte are registered and offered from the next cycle on.
// Throughput: one byte per cycle while each byte gives at most one word and out_ready_i
//   is high; a byte giving n words (n up to 3) holds the input while the buffer drains.
// A new byte is taken in the same cycle as the last word of its predecessor's run leaves.
// Reset (rst_ni low, asynchronous): segment state, convert mode, buffer pointers cleared.
module form_urlencoded_decoder_core
  import fud_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  dec_state_t  st_q, st_d;
  logic        conv_q;
  out_word_t   res [MaxRes];
  logic [1:0]  cnt;
  logic        space;
  logic        in_take;
  buf_status_t buf_st;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = space;
  assign in_take     = in_valid_i && space;

  // convert mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q <= 1'b0;
    end else if (cfg_valid_i) begin
      conv_q <= cfg_data_i;
    end
  end

  // segment state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: ESC_NONE, high_nibble: 4'h0, seen_equals: 1'b0, body_stopped: 1'b0};
    end else if (in_take) begin
      st_q <= st_d;
    end
  end

  fud_decode u_decode (
    .in_i   (in_data_i),
    .st_i   (st_q),
    .conv_i (conv_q),
    .st_o   (st_d),
    .res_o  (res),
    .cnt_o  (cnt)
  );

  fud_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_take),
    .res_i       (res),
    .cnt_i       (cnt),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .status_o    (buf_st)
  );

  // Checks
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_st.idx <= buf_st.cnt)
    else $error("result pointer ran past the run");

  a_word_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.char_valid && out_data_o.pair_end))
    else $error("word is both character and pair end");

  a_run_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && cnt != 2'd0) |=> out_valid_o)
    else $error("accepted run not offered");

  a_stopped_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.body_stopped |-> (st_q.phase == ESC_NONE && !st_q.seen_equals))
    else $error("stopped body holds segment state");

endmodule
